// File: hw/rtl/ibat_pkg.sv
// Package for the inode bitmap allocator: payload structs, operation and status codes,
// sequencer states and bitmap word constants. No dependencies.
package ibat_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_IDX_W = 5;
   localparam int FUNC_W    = 2;
   localparam int ID_W      = 11;
   localparam int BLK_W     = 32;
   localparam int STATUS_W  = 2;

   localparam logic [FUNC_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [FUNC_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [FUNC_W-1:0] OP_FREE   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NORES = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVAL = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   inode_number;
      logic [BLK_W-1:0]  block_number;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     result_inode;
      logic [BLK_W-1:0]    result_block;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_FREE_WR,
      S_LOOK_RD,
      S_LOOK_CHK,
      S_RESP
   } state_type;

endpackage

// File: hw/rtl/ibat_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on ibat_pkg for the payload structs.
interface ibat_req_if;
   import ibat_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ibat_rsp_if;
   import ibat_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/ibat_first_zero.sv
// Lowest-free-bit finder for one bitmap word; the shared unit of the allocate scan.
// Depends on ibat_pkg for the word width constants.
module ibat_first_zero (
   input  logic [ibat_pkg::WORD_BITS-1:0] word,
   input  logic [ibat_pkg::WORD_BITS-1:0] mask,
   output logic                           found,
   output logic [ibat_pkg::BIT_IDX_W-1:0] bit_idx
);
   import ibat_pkg::*;

   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] lowest;

   assign free_bits = ~word & mask;
   // isolate the lowest set bit
   assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));
   assign found     = |free_bits;

   always_comb begin
      bit_idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (lowest[b]) begin
            bit_idx = bit_idx | BIT_IDX_W'(b);
         end
      end
   end
endmodule

// File: hw/rtl/inode_bitmap_allocator_table.sv
// Inode bitmap allocator with slot-to-block table. After reset a clearing pass zeroes
// both memories; no request is taken meanwhile.
// Allocate: a word-serial bitmap scan finds the lowest free slot.
// Lookup and free: registered memory reads; free also does a bitmap read-modify-write.
// One request at a time; the next one is taken while the last response waits.
// Depends on ibat_pkg, ibat_channels and ibat_first_zero.
module inode_bitmap_allocator_table #(
   parameter int NUM_INODES = 1024
) (
   input  logic              clock,
   input  logic              reset,
   ibat_req_if.sink          req_ch,
   ibat_rsp_if.source        rsp_ch
);
   import ibat_pkg::*;

   localparam int NUM_WORDS = (NUM_INODES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int SLOT_W    = $clog2(NUM_INODES);
   localparam int SCAN_W    = WORD_W + BIT_IDX_W;
   localparam int CMP_W     = (SCAN_W + 1 > ID_W) ? SCAN_W + 1 : ID_W;
   localparam int LAST_WORD = NUM_WORDS - 1;
   localparam int LAST_BITS = NUM_INODES - LAST_WORD * WORD_BITS;
   localparam logic [WORD_BITS-1:0] LAST_MASK =
      (LAST_BITS == WORD_BITS) ? '1 : WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

   // storage: one used bit per slot, packed 32 to a word, and the block table
   logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
   logic [BLK_W-1:0]     slot_mem   [NUM_INODES];

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [BLK_W-1:0]      bnum_ff, bnum_in;
   logic [WORD_W-1:0]     rd_w_ff, rd_w_in;
   logic [WORD_W-1:0]     chk_w_ff, chk_w_in;
   logic                  chk_vld_ff, chk_vld_in;
   rsp_payload_type       res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [WORD_BITS-1:0]  bm_rdata_ff;
   logic [BLK_W-1:0]      tb_rdata_ff;

   logic                  bm_we;
   logic [WORD_W-1:0]     bm_waddr, bm_raddr;
   logic [WORD_BITS-1:0]  bm_wdata;
   logic                  tb_we;
   logic [SLOT_W-1:0]     tb_waddr;
   logic [BLK_W-1:0]      tb_wdata;

   // request decode
   logic [CMP_W-1:0]      id_ext, id_m1;
   logic                  id_ok;
   assign id_ext = CMP_W'(req_ch.payload.inode_number);
   assign id_m1  = id_ext - CMP_W'(1);
   assign id_ok  = (id_ext != '0) && (id_ext <= CMP_W'(NUM_INODES));

   // held slot split into bitmap word and bit
   logic [SCAN_W-1:0]     slot_ext;
   logic [WORD_W-1:0]     slot_word;
   logic [WORD_BITS-1:0]  slot_onehot;
   assign slot_ext    = SCAN_W'(slot_ff);
   assign slot_word   = slot_ext[SCAN_W-1:BIT_IDX_W];
   assign slot_onehot = WORD_BITS'(1) << slot_ext[BIT_IDX_W-1:0];

   // scan unit: the last word masks off bits past the table end
   logic                  chk_last;
   logic [WORD_BITS-1:0]  scan_mask;
   logic                  scan_found;
   logic [BIT_IDX_W-1:0]  scan_bit;
   logic [SCAN_W-1:0]     found_slot;
   logic [CMP_W-1:0]      found_id;

   assign chk_last   = (chk_w_ff == WORD_W'(LAST_WORD));
   assign scan_mask  = chk_last ? LAST_MASK : '1;
   assign found_slot = {chk_w_ff, scan_bit};
   assign found_id   = CMP_W'(found_slot) + CMP_W'(1);

   ibat_first_zero u_first_zero (
      .word    (bm_rdata_ff),
      .mask    (scan_mask),
      .found   (scan_found),
      .bit_idx (scan_bit)
   );

   logic rsp_load;
   assign rsp_load = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // sequencer: next state, memory controls, result capture
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      slot_in      = slot_ff;
      bnum_in      = bnum_ff;
      rd_w_in      = rd_w_ff;
      chk_w_in     = chk_w_ff;
      chk_vld_in   = chk_vld_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      bm_we    = 1'b0;
      bm_waddr = slot_word;
      bm_wdata = bm_rdata_ff & ~slot_onehot;
      bm_raddr = slot_word;
      tb_we    = 1'b0;
      tb_waddr = slot_ff;
      tb_wdata = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one table entry per cycle, and the bitmap words along the way
            tb_we    = 1'b1;
            tb_waddr = clr_cnt_ff;
            bm_we    = (SCAN_W'(clr_cnt_ff) < SCAN_W'(NUM_WORDS));
            bm_waddr = clr_cnt_ff[WORD_W-1:0];
            bm_wdata = '0;
            if (clr_cnt_ff == SLOT_W'(NUM_INODES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + SLOT_W'(1);
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               slot_in    = id_m1[SLOT_W-1:0];
               bnum_in    = req_ch.payload.block_number;
               res_in     = '{status: ST_INVAL, result_inode: '0, result_block: '0};
               rd_w_in    = '0;
               chk_vld_in = 1'b0;
               case (req_ch.payload.func)
                  OP_ALLOC:  state_in = S_SCAN;
                  OP_LOOKUP: state_in = id_ok ? S_LOOK_RD : S_RESP;
                  OP_FREE:   state_in = id_ok ? S_FREE_RD : S_RESP;
                  default:   state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            // issue one word read per cycle; check the registered word of the previous read
            bm_raddr   = rd_w_ff;
            chk_w_in   = rd_w_ff;
            chk_vld_in = 1'b1;
            if (rd_w_ff != WORD_W'(LAST_WORD)) begin
               rd_w_in = rd_w_ff + WORD_W'(1);
            end
            if (chk_vld_ff) begin
               if (scan_found) begin
                  bm_we    = 1'b1;
                  bm_waddr = chk_w_ff;
                  bm_wdata = bm_rdata_ff | (WORD_BITS'(1) << scan_bit);
                  tb_we    = 1'b1;
                  tb_waddr = found_slot[SLOT_W-1:0];
                  tb_wdata = bnum_ff;
                  res_in   = '{status: ST_OK, result_inode: found_id[ID_W-1:0],
                               result_block: '0};
                  state_in = S_RESP;
               end else if (chk_last) begin
                  res_in   = '{status: ST_NORES, result_inode: '0, result_block: '0};
                  state_in = S_RESP;
               end
            end
         end
         S_FREE_RD: begin
            // drop the table entry, fetch the bitmap word
            tb_we    = 1'b1;
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            bm_we    = 1'b1;
            res_in   = '{status: ST_OK, result_inode: '0, result_block: '0};
            state_in = S_RESP;
         end
         S_LOOK_RD: begin
            state_in = S_LOOK_CHK;
         end
         S_LOOK_CHK: begin
            if (tb_rdata_ff != '0) begin
               res_in = '{status: ST_OK, result_inode: '0, result_block: tb_rdata_ff};
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold until the output register frees up
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      bnum_ff     <= bnum_in;
      rd_w_ff     <= rd_w_in;
      chk_w_ff    <= chk_w_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // bitmap memory
   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem[bm_waddr] <= bm_wdata;
      end
      bm_rdata_ff <= bitmap_mem[bm_raddr];
   end

   // block table memory
   always_ff @(posedge clock) begin
      if (tb_we) begin
         slot_mem[tb_waddr] <= tb_wdata;
      end
      tb_rdata_ff <= slot_mem[slot_ff];
   end

endmodule
